// File: design/bsmv_pkg.sv
package bsmv_pkg;

   // Word field widths
   localparam int OP_W       = 2;
   localparam int VIDX_W     = 10;
   localparam int COL_W      = 20;
   localparam int VAL_W      = 32;
   localparam int ROW_W      = 20;
   localparam int ABS_ROW_W  = 21;
   localparam int SUM_W      = 64;

   // Configuration register widths
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 21;
   localparam int VLEN_W     = 11;
   localparam int RCNT_W     = 21;

   // Operation codes
   typedef enum logic [OP_W-1:0] {
      OP_LOAD = 2'd0,
      OP_ELEM = 2'd1,
      OP_END  = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COL_OFFSET = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VEC_LEN    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_ROW  = 2'd3;

   // Register reset values
   localparam logic [COL_W-1:0]  COL_OFFSET_RST = '0;
   localparam logic [VLEN_W-1:0] VEC_LEN_RST    = 11'd1024;
   localparam logic [RCNT_W-1:0] ROW_COUNT_RST  = 21'd1;
   localparam logic [ROW_W-1:0]  FIRST_ROW_RST  = '0;

   // Saturation limits
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

endpackage

// File: design/bsmv_if.sv
interface bsmv_req_if;
   import bsmv_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic [VIDX_W-1:0]        vec_index;
   logic [COL_W-1:0]         column;
   logic signed [VAL_W-1:0]  value;

   modport source (output valid, op, vec_index, column, value, input ready);
   modport sink   (input valid, op, vec_index, column, value, output ready);
endinterface

interface bsmv_rsp_if;
   import bsmv_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [ROW_W-1:0]         row_index;
   logic [ABS_ROW_W-1:0]     abs_row;
   logic signed [SUM_W-1:0]  row_sum;
   logic                     last_row;

   modport source (output valid, row_index, abs_row, row_sum, last_row, input ready);
   modport sink   (input valid, row_index, abs_row, row_sum, last_row, output ready);
endinterface

// File: design/block_sparse_matrix_vector_multiply.sv
// Sparse row times dense vector, Q16.16 operands and a saturating Q32.32 row sum.
// The block takes one word per cycle while the input is not stalled. Load words
// write the vector memory at once; element words then pass a three-step pipe:
// registered vector memory read, a 32x32 multiply into a product register, and
// the 64-bit saturating add into the accumulator. A row-end word passes the read
// and product registers, and its row sum then moves from the accumulator into
// the output register. The input stalls only while a row-end word sits in the
// accumulate step and the previous sum is still held in the output register.
// The vector memory has no clearing pass: an entry must be loaded before an
// element reads it. Configuration may be written only while the pipe is empty.
module block_sparse_matrix_vector_multiply #(
   parameter int VEC_DEPTH = 1024,
   parameter int COL_BITS  = 20
) (
   input  logic                               clock,
   input  logic                               reset,
   bsmv_req_if.sink                           req_ch,
   bsmv_rsp_if.source                         rsp_ch,
   input  logic                               csr_write_enable,
   input  logic [bsmv_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bsmv_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import bsmv_pkg::*;

   localparam int AddrBits = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;
   localparam int ColKeep  = (COL_BITS < COL_W) ? COL_BITS : COL_W;
   localparam logic [COL_W-1:0] ColMask = COL_W'((64'd1 << ColKeep) - 64'd1);

   // Configuration registers
   logic [COL_W-1:0]     col_offset_ff;
   logic [VLEN_W-1:0]    vec_len_ff;
   logic [RCNT_W-1:0]    row_count_ff;
   logic [ROW_W-1:0]     first_row_ff;

   // Vector memory and its read data
   logic [VAL_W-1:0]     store_mem [VEC_DEPTH];
   logic signed [VAL_W-1:0] rdata_ff;

   // Read stage
   logic                 s1_valid_ff;
   logic                 s1_end_ff;
   logic signed [VAL_W-1:0] s1_value_ff;

   // Product stage
   logic                 s2_valid_ff;
   logic                 s2_end_ff;
   logic signed [SUM_W-1:0] s2_prod_ff;
   logic signed [SUM_W-1:0] s2_prod_in;

   // Accumulate state
   logic signed [SUM_W-1:0] acc_ff;
   logic signed [SUM_W-1:0] acc_in;
   logic [ROW_W-1:0]     row_ff;
   logic [ROW_W-1:0]     row_in;
   logic                 last_in;

   // Output register
   logic                 rsp_valid_ff;
   logic [ROW_W-1:0]     rsp_row_ff;
   logic [ABS_ROW_W-1:0] rsp_abs_ff;
   logic signed [SUM_W-1:0] rsp_sum_ff;
   logic                 rsp_last_ff;

   // Decode
   logic                 advance;
   logic                 accept;
   logic                 emit;
   logic                 is_load;
   logic                 is_elem;
   logic                 is_end;
   logic                 load_ok;
   logic                 col_hit;
   logic [COL_W-1:0]     col_masked;
   logic [COL_W-1:0]     col_rel;
   logic [AddrBits-1:0]  wr_addr;
   logic [AddrBits-1:0]  rd_addr;
   logic signed [SUM_W-1:0] sum_raw;
   logic                 sum_ovf;

   // Hold the pipe only when a row sum cannot leave
   assign emit    = s2_valid_ff && s2_end_ff;
   assign advance = !(emit && rsp_valid_ff && !rsp_ch.ready);
   assign req_ch.ready = advance;
   assign accept  = req_ch.valid && advance;

   assign is_load = (req_ch.op == OP_LOAD);
   assign is_elem = (req_ch.op == OP_ELEM);
   assign is_end  = (req_ch.op == OP_END);

   // Address decode for loads and elements
   assign load_ok    = (32'(req_ch.vec_index) < VEC_DEPTH);
   assign wr_addr    = AddrBits'(req_ch.vec_index);
   assign col_masked = req_ch.column & ColMask;
   assign col_rel    = col_masked - col_offset_ff;
   assign col_hit    = (col_masked >= col_offset_ff)
                       && (32'(col_rel) < 32'(vec_len_ff))
                       && (32'(col_rel) < VEC_DEPTH);
   assign rd_addr    = AddrBits'(col_rel);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         col_offset_ff <= COL_OFFSET_RST;
         vec_len_ff    <= VEC_LEN_RST;
         row_count_ff  <= ROW_COUNT_RST;
         first_row_ff  <= FIRST_ROW_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_COL_OFFSET: col_offset_ff <= csr_write_data[COL_W-1:0];
            CSR_VEC_LEN:    vec_len_ff    <= csr_write_data[VLEN_W-1:0];
            CSR_ROW_COUNT:  row_count_ff  <= csr_write_data[RCNT_W-1:0];
            CSR_FIRST_ROW:  first_row_ff  <= csr_write_data[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   // Vector memory: write on load, read as the element enters
   always_ff @(posedge clock) begin
      if (accept && is_load && load_ok) begin
         store_mem[wr_addr] <= req_ch.value;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rdata_ff <= store_mem[rd_addr];
      end
   end

   // Read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept && ((is_elem && col_hit) || is_end);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_end_ff   <= is_end;
         s1_value_ff <= req_ch.value;
      end
   end

   // Product stage
   assign s2_prod_in = SUM_W'(s1_value_ff) * SUM_W'(rdata_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_end_ff  <= s1_end_ff;
         s2_prod_ff <= s2_prod_in;
      end
   end

   // Saturating accumulate, row bookkeeping
   assign sum_raw = acc_ff + s2_prod_ff;
   assign sum_ovf = (acc_ff[SUM_W-1] == s2_prod_ff[SUM_W-1])
                    && (sum_raw[SUM_W-1] != acc_ff[SUM_W-1]);
   assign last_in = ((RCNT_W'(row_ff) + RCNT_W'(1)) == row_count_ff);

   always_comb begin
      acc_in = acc_ff;
      row_in = row_ff;
      if (advance && s2_valid_ff) begin
         if (s2_end_ff) begin
            acc_in = '0;
            row_in = last_in ? '0 : row_ff + ROW_W'(1);
         end else if (sum_ovf) begin
            acc_in = acc_ff[SUM_W-1] ? SUM_MIN : SUM_MAX;
         end else begin
            acc_in = sum_raw;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         row_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         row_ff <= row_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_row_ff  <= row_ff;
         rsp_abs_ff  <= ABS_ROW_W'(first_row_ff) + ABS_ROW_W'(row_ff);
         rsp_sum_ff  <= acc_ff;
         rsp_last_ff <= last_in;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.row_index = rsp_row_ff;
   assign rsp_ch.abs_row   = rsp_abs_ff;
   assign rsp_ch.row_sum   = rsp_sum_ff;
   assign rsp_ch.last_row  = rsp_last_ff;

   // Stall only with a row sum blocked behind a held output word
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (s2_valid_ff && s2_end_ff && rsp_valid_ff))
      else $error("input stalled without a blocked row sum");

   // Reset clears the row state
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (acc_ff == '0) && (row_ff == '0) && !rsp_valid_ff)
      else $error("row state not cleared by reset");

   // A row sum that leaves clears the accumulator and fills the output
   a_emit_clear: assert property (@(posedge clock) disable iff (reset)
      (advance && emit) |=> (acc_ff == '0) && rsp_valid_ff)
      else $error("row end did not clear accumulator or load output");

   // A row sum in the output cannot be overwritten
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |=> rsp_valid_ff && $stable(rsp_sum_ff))
      else $error("held row sum lost");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import bsmv_pkg::*;

   typedef struct packed {
      logic [ROW_W-1:0]     row_index;
      logic [ABS_ROW_W-1:0] abs_row;
      logic [SUM_W-1:0]     row_sum;
      logic                 last_row;
   } row_result_type;

   typedef struct packed {
      op_type             op;
      logic [VIDX_W-1:0]  vec_index;
      logic [COL_W-1:0]   column;
      logic [VAL_W-1:0]   value;
      logic               has_sum;
      row_result_type     sum;
   } word_type;

   localparam int VEC_DEPTH   = 1024;
   localparam int COL_SPAN    = 1 << COL_W;
   localparam int N_DIRECTED  = 22;
   localparam int N_PHASES    = 10;
   localparam int PHASE_WORDS = 200;
   localparam int HOLD_CYCLES = 400;
   localparam row_result_type NO_SUM = '0;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_COL_OFFSET;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   bsmv_req_if req_if();
   bsmv_rsp_if rsp_if();

   block_sparse_matrix_vector_multiply dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_if),
      .rsp_ch           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Dot product state mirrored from the block
   logic [VAL_W-1:0]  vec_mem [VEC_DEPTH];
   logic [SUM_W-1:0]  acc = '0;
   logic [ROW_W-1:0]  row_ctr = '0;
   logic [COL_W-1:0]  cfg_col_offset = COL_OFFSET_RST;
   logic [VLEN_W-1:0] cfg_vec_len = VEC_LEN_RST;
   logic [RCNT_W-1:0] cfg_row_count = ROW_COUNT_RST;
   logic [ROW_W-1:0]  cfg_first_row = FIRST_ROW_RST;

   row_result_type pending_sums [$];
   int          mismatches = 0;
   int          sums_seen = 0;
   int          words_sent = 0;
   bit          hold_done = 1'b0;
   bit          req_gappy = 1'b1;
   word_type    cur_word;

   // Vector entries loaded so far, so elements only read written entries
   bit loaded [VEC_DEPTH];
   int loaded_list [$];

   word_type directed [N_DIRECTED] = '{
      '{OP_END,  10'd0,    20'd0,      32'h0000_0000, 1'b1, '{20'd0, 21'd0, 64'd0, 1'b1}},
      '{OP_LOAD, 10'd0,    20'd0,      32'h7FFF_FFFF, 1'b0, NO_SUM},
      '{OP_LOAD, 10'd1023, 20'd0,      32'h8000_0000, 1'b0, NO_SUM},
      '{OP_LOAD, 10'd5,    20'd0,      32'h0001_0000, 1'b0, NO_SUM},
      '{OP_ELEM, 10'd0,    20'd0,      32'h7FFF_FFFF, 1'b0, NO_SUM},
      '{OP_ELEM, 10'd0,    20'd0,      32'h7FFF_FFFF, 1'b0, NO_SUM},
      '{OP_ELEM, 10'd0,    20'd0,      32'h7FFF_FFFF, 1'b0, NO_SUM},
      '{OP_END,  10'd0,    20'd0,      32'h0000_0000, 1'b1, '{20'd0, 21'd0, SUM_MAX, 1'b1}},
      '{OP_ELEM, 10'd0,    20'd1023,   32'h7FFF_FFFF, 1'b0, NO_SUM},
      '{OP_ELEM, 10'd0,    20'd1023,   32'h7FFF_FFFF, 1'b0, NO_SUM},
      '{OP_ELEM, 10'd0,    20'd1023,   32'h7FFF_FFFF, 1'b0, NO_SUM},
      '{OP_END,  10'd0,    20'd0,      32'h0000_0000, 1'b1, '{20'd0, 21'd0, SUM_MIN, 1'b1}},
      '{OP_ELEM, 10'd0,    20'd1023,   32'h8000_0000, 1'b0, NO_SUM},
      '{OP_ELEM, 10'd0,    20'd5,      32'h0001_0000, 1'b0, NO_SUM},
      '{OP_ELEM, 10'd0,    20'hF_FFFF, 32'hFFFF_FFFF, 1'b0, NO_SUM},
      '{OP_ELEM, 10'd0,    20'd1024,   32'h7FFF_FFFF, 1'b0, NO_SUM},
      '{OP_NONE, 10'd1023, 20'hF_FFFF, 32'hFFFF_FFFF, 1'b0, NO_SUM},
      '{OP_END,  10'd0,    20'd0,      32'h0000_0000, 1'b0, NO_SUM},
      '{OP_LOAD, 10'd1023, 20'hF_FFFF, 32'hFFFF_FFFF, 1'b0, NO_SUM},
      '{OP_ELEM, 10'd0,    20'd1023,   32'h8000_0000, 1'b0, NO_SUM},
      '{OP_ELEM, 10'd0,    20'd0,      32'h0000_0000, 1'b0, NO_SUM},
      '{OP_END,  10'd0,    20'd0,      32'h0000_0000, 1'b0, NO_SUM}
   };

   function automatic int kept_len();
      return (cfg_vec_len < VEC_DEPTH) ? int'(cfg_vec_len) : VEC_DEPTH;
   endfunction

   function automatic bit in_block(logic [COL_W-1:0] col);
      return col >= cfg_col_offset && int'(col - cfg_col_offset) < kept_len();
   endfunction

   // Columns of the block that also fit in the column field
   function automatic int reach();
      int lim;
      lim = kept_len();
      if (COL_SPAN - int'(cfg_col_offset) < lim) lim = COL_SPAN - int'(cfg_col_offset);
      return lim;
   endfunction

   // Advance the dot product by one word; report the row sum on a row end
   task automatic predict_word(input word_type w, output bit emits,
                               output row_result_type res);
      logic [VAL_W-1:0] entry;
      logic [SUM_W-1:0] prod;
      logic [SUM_W-1:0] total;
      logic [COL_W-1:0] j;
      bit               last;
      emits = 1'b0;
      res = NO_SUM;
      case (w.op)
         OP_LOAD: vec_mem[w.vec_index] = w.value;
         OP_ELEM: begin
            if (in_block(w.column)) begin
               j = w.column - cfg_col_offset;
               entry = vec_mem[j[VIDX_W-1:0]];
               prod = {{(SUM_W-VAL_W){w.value[VAL_W-1]}}, w.value} *
                      {{(SUM_W-VAL_W){entry[VAL_W-1]}}, entry};
               total = acc + prod;
               // clamp when both addends share a sign the sum lost
               if (acc[SUM_W-1] == prod[SUM_W-1] && total[SUM_W-1] != acc[SUM_W-1])
                  total = acc[SUM_W-1] ? SUM_MIN : SUM_MAX;
               acc = total;
            end
         end
         OP_END: begin
            last = ({1'b0, row_ctr} + 21'd1) == cfg_row_count;
            res.row_index = row_ctr;
            res.abs_row = {1'b0, cfg_first_row} + {1'b0, row_ctr};
            res.row_sum = acc;
            res.last_row = last;
            emits = 1'b1;
            acc = '0;
            row_ctr = last ? '0 : row_ctr + 1'b1;
         end
         default: ;
      endcase
   endtask

   // Check row sums, predict on accepted words, track register writes
   always @(posedge clock) begin
      row_result_type got;
      row_result_type want;
      row_result_type model;
      word_type    w;
      bit          emits;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.row_index, rsp_if.abs_row, rsp_if.row_sum, rsp_if.last_row};
            sums_seen++;
            if (pending_sums.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected row sum: row %0d abs %0d sum %0d last %0b",
                           got.row_index, got.abs_row, $signed(got.row_sum), got.last_row);
            end else begin
               want = pending_sums.pop_front();
               if (got.row_index !== want.row_index || got.abs_row !== want.abs_row ||
                   got.row_sum !== want.row_sum || got.last_row !== want.last_row) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("row sum mismatch: expected row %0d abs %0d sum %0d last %0b, %s",
                              want.row_index, want.abs_row, $signed(want.row_sum),
                              want.last_row, $sformatf("got row %0d abs %0d sum %0d last %0b",
                              got.row_index, got.abs_row, $signed(got.row_sum), got.last_row));
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            w = cur_word;
            w.op = op_type'(req_if.op);
            w.vec_index = req_if.vec_index;
            w.column = req_if.column;
            w.value = req_if.value;
            predict_word(w, emits, model);
            if (emits) pending_sums.push_back(cur_word.has_sum ? cur_word.sum : model);
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_COL_OFFSET: cfg_col_offset = csr_write_data[COL_W-1:0];
               CSR_VEC_LEN:    cfg_vec_len = csr_write_data[VLEN_W-1:0];
               CSR_ROW_COUNT:  cfg_row_count = csr_write_data[RCNT_W-1:0];
               CSR_FIRST_ROW:  cfg_first_row = csr_write_data[ROW_W-1:0];
               default: ;
            endcase
         end
      end
   end

   function automatic logic [VAL_W-1:0] rand_value();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return '0;
         3: return VAL_W'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
         default: return VAL_W'($urandom);
      endcase
   endfunction

   function automatic void mark_loaded(int idx);
      if (!loaded[idx]) begin
         loaded[idx] = 1'b1;
         loaded_list.push_back(idx);
      end
   endfunction

   // Mostly indexes the current block can read
   function automatic logic [VIDX_W-1:0] pick_index();
      int lim;
      lim = reach();
      if (lim > 0 && $urandom_range(0, 4) != 0) return VIDX_W'($urandom_range(0, lim - 1));
      return VIDX_W'($urandom);
   endfunction

   function automatic word_type load_word(logic [VIDX_W-1:0] idx);
      word_type w;
      w = '0;
      w.op = OP_LOAD;
      w.vec_index = idx;
      w.column = COL_W'($urandom);
      w.value = rand_value();
      mark_loaded(int'(idx));
      return w;
   endfunction

   function automatic word_type noise_word();
      word_type w;
      w = '0;
      w.op = OP_NONE;
      w.vec_index = VIDX_W'($urandom);
      w.column = COL_W'($urandom);
      w.value = VAL_W'($urandom);
      return w;
   endfunction

   // Column that the block drops, often right at an edge of the block
   function automatic logic [COL_W-1:0] outside_column(int lim);
      logic [COL_W-1:0] c;
      int               r;
      r = $urandom_range(0, 3);
      if (r == 0 && cfg_col_offset != 0) return cfg_col_offset - 1'b1;
      if (r == 1 && int'(cfg_col_offset) + lim < COL_SPAN)
         return COL_W'(int'(cfg_col_offset) + lim);
      do c = COL_W'($urandom); while (in_block(c));
      return c;
   endfunction

   // Element hitting a loaded entry when one is found, else a dropped column
   function automatic word_type element_word();
      word_type w;
      int    lim;
      int    j;
      bit    hit;
      w = '0;
      w.op = OP_ELEM;
      w.vec_index = VIDX_W'($urandom);
      w.value = rand_value();
      lim = reach();
      hit = 1'b0;
      j = 0;
      w.column = outside_column(lim);
      if (lim > 0 && $urandom_range(0, 9) < 8) begin
         for (int t = 0; t < 12 && !hit; t++) begin
            j = (t % 2 == 0) ? loaded_list[$urandom_range(0, loaded_list.size() - 1)]
                             : $urandom_range(0, lim - 1);
            hit = j < lim && loaded[j];
         end
         if (hit) w.column = COL_W'(int'(cfg_col_offset) + j);
      end
      return w;
   endfunction

   function automatic int gap_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (!req_gappy || r < 70) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Offer one word from a falling edge, hold it until taken, then idle a while
   task automatic send_word(input word_type w);
      int n;
      cur_word = w;
      req_if.valid <= 1'b1;
      req_if.op <= w.op;
      req_if.vec_index <= w.vec_index;
      req_if.column <= w.column;
      req_if.value <= w.value;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      words_sent++;
      if (words_sent % 64 == 0) req_gappy = $urandom_range(0, 3) != 0;
      n = gap_cycles();
      if (n > 0) begin
         req_if.valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // One matrix row; now and then the row end is left out
   task automatic send_row();
      int n;
      word_type w;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      repeat (n) begin
         if ($urandom_range(0, 19) == 0) send_word(load_word(pick_index()));
         send_word(element_word());
      end
      if ($urandom_range(0, 19) != 0) begin
         w = '0;
         w.op = OP_END;
         w.vec_index = VIDX_W'($urandom);
         w.column = COL_W'($urandom);
         w.value = VAL_W'($urandom);
         send_word(w);
      end
   endtask

   // Stop offering words and let the pipe empty
   task automatic drain();
      req_if.valid <= 1'b0;
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] col_off, vlen, rcnt, frow);
      logic [CSR_DATA_W-1:0] vals [4];
      logic [CSR_IDX_W-1:0]  regs [4];
      vals = '{col_off, vlen, rcnt, frow};
      regs = '{CSR_COL_OFFSET, CSR_VEC_LEN, CSR_ROW_COUNT, CSR_FIRST_ROW};
      for (int i = 0; i < 4; i++) begin
         csr_write_enable <= 1'b1;
         csr_index <= regs[i];
         csr_write_data <= vals[i];
         @(negedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   // Stimulus: directed table, then phases of random rows under new settings
   initial begin
      logic [COL_W-1:0]  c_off;
      logic [VLEN_W-1:0] c_len;
      logic [RCNT_W-1:0] c_rows;
      logic [ROW_W-1:0]  c_first;
      int                r;
      int                phase_end;
      req_if.valid = 1'b0;
      req_if.op = OP_NONE;
      req_if.vec_index = '0;
      req_if.column = '0;
      req_if.value = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++) begin
         if (directed[i].op == OP_LOAD) mark_loaded(int'(directed[i].vec_index));
         send_word(directed[i]);
      end

      for (int ph = 0; ph < N_PHASES; ph++) begin
         case (ph)
            0: begin
               c_off = '0; c_len = 11'd1024; c_rows = 21'd3; c_first = 20'hF_FFFF;
            end
            1: begin
               c_off = 20'hF_FFFF; c_len = 11'd1; c_rows = 21'd1; c_first = '0;
            end
            2: begin
               c_off = 20'hF_FC00; c_len = 11'd2047; c_rows = '0; c_first = 20'd12345;
            end
            3: begin
               c_off = 20'd1000; c_len = '0; c_rows = 21'h1F_FFFF; c_first = 20'd7;
            end
            4: begin
               c_off = '0; c_len = 11'd1; c_rows = 21'd2; c_first = '0;
            end
            default: begin
               c_off = ($urandom_range(0, 1) == 0) ? COL_W'($urandom_range(0, 2000))
                                                   : COL_W'($urandom);
               r = $urandom_range(0, 19);
               c_len = (r < 14) ? VLEN_W'($urandom_range(1, 1024)) :
                       (r < 17) ? VLEN_W'($urandom_range(1025, 2047)) : '0;
               r = $urandom_range(0, 19);
               c_rows = (r < 14) ? RCNT_W'($urandom_range(1, 8)) :
                        (r < 16) ? '0 : RCNT_W'($urandom);
               c_first = ROW_W'($urandom);
            end
         endcase
         drain();
         // unused upper data bits carry noise
         configure({1'($urandom), c_off}, {10'($urandom), c_len}, c_rows,
                   {1'($urandom), c_first});
         repeat (16) send_word(load_word(pick_index()));
         phase_end = words_sent + PHASE_WORDS;
         while (words_sent < phase_end) begin
            r = $urandom_range(0, 99);
            if (r < 6) send_word(load_word(pick_index()));
            else if (r < 9) send_word(noise_word());
            else if (r < 12) send_word(element_word());
            else send_row();
         end
      end

      drain();
      if (mismatches == 0) begin
         $display("block_sparse_matrix_vector_multiply: match");
      end else begin
         $display("block_sparse_matrix_vector_multiply: mismatch");
      end
      $finish;
   end

   // Result side: random stalls, and once a long hold so the block backs up
   initial begin
      int seg;
      int mode;
      rsp_if.ready = 1'b0;
      @(negedge reset);
      forever begin
         if (!hold_done && sums_seen >= 40) begin
            hold_done = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         mode = $urandom_range(0, 9);
         seg = (mode == 9) ? $urandom_range(20, 80) : $urandom_range(1, 40);
         repeat (seg) begin
            case (mode)
               0, 1, 2, 3: rsp_if.ready <= 1'b1;
               4, 5, 6, 7: rsp_if.ready <= 1'($urandom_range(0, 1));
               8:          rsp_if.ready <= ($urandom_range(0, 7) == 0);
               default:    rsp_if.ready <= 1'b0;
            endcase
            @(negedge clock);
         end
      end
   end

   // Give up on a hung run
   initial begin
      #5_000_000;
      $display("block_sparse_matrix_vector_multiply: mismatch");
      $finish;
   end

endmodule
